### rtl/ssd_pkg.sv
// shared widths, latencies and beat types for the segment distance block
package ssd_pkg;

   localparam int COORD_W     = 24;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int DOT_W       = PROD_W + 1;
   localparam int WIDE_W      = 2 * DOT_W;
   localparam int MUL_LO_W    = (DOT_W + 1) / 2;
   localparam int MUL_HI_W    = DOT_W - MUL_LO_W;
   localparam int LIMIT_W     = 32;
   localparam int FRAC_BITS   = 16;
   localparam int FRAC_W      = FRAC_BITS + 1;
   localparam int ALONG_W     = FRAC_W + 1 + DIFF_W;
   localparam int SUM_W       = ALONG_W + 2;
   localparam int DELTA_W     = 27;
   localparam int SQ_W        = 2 * DELTA_W;
   localparam int ROOT_W      = DELTA_W;
   localparam int DIST_W      = 25;
   localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);
   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_AW    = 4;
   localparam int CREDIT_W    = QUEUE_AW + 1;
   localparam int FRONT_LAT   = 8;
   localparam int DOT_STAGES  = 5;
   localparam int DIV_LAT     = FRAC_BITS + 2;
   localparam int SQRT_LAT    = ROOT_W;
   localparam int PT_LAT      = SQRT_LAT + 3;
   localparam int BACK_LAT    = DIV_LAT + SQRT_LAT + 5;

   localparam logic [FRAC_W-1:0]  FRAC_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

   typedef struct packed {
      logic [2:0][DIFF_W-1:0]  da;
      logic [2:0][DIFF_W-1:0]  db;
      logic [2:0][DIFF_W-1:0]  gp;
      logic [2:0][COORD_W-1:0] qs;
   } geom_type;

   typedef struct packed {
      logic [2:0][PROD_W-1:0] uu;
      logic [2:0][PROD_W-1:0] uv;
      logic [2:0][PROD_W-1:0] vv;
      logic [2:0][PROD_W-1:0] uw;
      logic [2:0][PROD_W-1:0] vw;
   } prods_type;

   typedef struct packed {
      logic [DOT_W-1:0] uu;
      logic [DOT_W-1:0] uv;
      logic [DOT_W-1:0] vv;
      logic [DOT_W-1:0] uw;
      logic [DOT_W-1:0] vw;
   } dots_type;

   typedef struct packed {
      logic [WIDE_W-1:0] num_s;
      logic [WIDE_W-1:0] den_s;
      logic [WIDE_W-1:0] num_t;
      logic [WIDE_W-1:0] den_t;
   } ratio_type;

   typedef struct packed {
      geom_type  geom;
      ratio_type ratio;
   } job_type;

endpackage

### rtl/ssd_wmul.sv
// two-stage signed multiplier for dot-product pairs, built from four partial products
module ssd_wmul import ssd_pkg::*; (
   input  logic                     clock,
   input  logic signed [DOT_W-1:0]  op_a,
   input  logic signed [DOT_W-1:0]  op_b,
   output logic signed [WIDE_W-1:0] product
);

   logic [DOT_W-1:0]            mag_a;
   logic [DOT_W-1:0]            mag_b;
   logic                        neg_in;
   logic                        neg_ff;
   logic [2*MUL_LO_W-1:0]       p_ll_in, p_ll_ff;
   logic [MUL_LO_W+MUL_HI_W-1:0] p_lh_in, p_lh_ff;
   logic [MUL_LO_W+MUL_HI_W-1:0] p_hl_in, p_hl_ff;
   logic [2*MUL_HI_W-1:0]       p_hh_in, p_hh_ff;
   logic [WIDE_W-1:0]           sum_in;
   logic signed [WIDE_W-1:0]    product_in, product_ff;

   always_comb begin
      mag_a   = op_a[DOT_W-1] ? (~op_a + DOT_W'(1)) : op_a;
      mag_b   = op_b[DOT_W-1] ? (~op_b + DOT_W'(1)) : op_b;
      neg_in  = op_a[DOT_W-1] ^ op_b[DOT_W-1];
      p_ll_in = mag_a[MUL_LO_W-1:0] * mag_b[MUL_LO_W-1:0];
      p_lh_in = mag_a[MUL_LO_W-1:0] * mag_b[DOT_W-1:MUL_LO_W];
      p_hl_in = mag_a[DOT_W-1:MUL_LO_W] * mag_b[MUL_LO_W-1:0];
      p_hh_in = mag_a[DOT_W-1:MUL_LO_W] * mag_b[DOT_W-1:MUL_LO_W];
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      p_ll_ff <= p_ll_in;
      p_lh_ff <= p_lh_in;
      p_hl_ff <= p_hl_in;
      p_hh_ff <= p_hh_in;
   end

   always_comb begin
      sum_in = WIDE_W'(p_ll_ff)
             + (WIDE_W'(p_lh_ff) << MUL_LO_W)
             + (WIDE_W'(p_hl_ff) << MUL_LO_W)
             + (WIDE_W'(p_hh_ff) << (2 * MUL_LO_W));
      product_in = neg_ff ? $signed(~sum_in + WIDE_W'(1)) : $signed(sum_in);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

### rtl/ssd_front.sv
// front end: takes a beat, forms dot products and determinant, clamps the line parameters
module ssd_front import ssd_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0][COORD_W-1:0]     seg_a_start,
   input  logic [2:0][COORD_W-1:0]     seg_a_end,
   input  logic [2:0][COORD_W-1:0]     seg_b_start,
   input  logic [2:0][COORD_W-1:0]     seg_b_end,
   input  logic [LIMIT_W-1:0]          limit,
   input  logic                        pop,
   output logic                        push,
   output job_type                     job
);

   logic                     accept;
   logic [CREDIT_W-1:0]      credit_in, credit_ff;
   logic [FRONT_LAT-1:0]     valid_in, valid_ff;
   geom_type                 geom_in;
   geom_type                 geom_ff [FRONT_LAT];
   prods_type                prods_in, prods_ff;
   dots_type                 dots_in;
   dots_type                 dots_ff [DOT_STAGES];
   logic signed [WIDE_W-1:0] p_uu_vv, p_uv_uv, p_uv_vw, p_vv_uw, p_uu_vw, p_uv_uw;
   logic signed [WIDE_W-1:0] det_in, det_ff, ns0_in, ns0_ff, nt0_in, nt0_ff;
   ratio_type                first_in, first_ff, second_in, second_ff;

   assign accept = start & ~busy;
   assign busy   = (credit_ff == CREDIT_W'(QUEUE_DEPTH));

   // credits cover the pipeline and the queue so the queue can never overflow
   always_comb begin
      credit_in = credit_ff + CREDIT_W'(accept) - CREDIT_W'(pop);
      valid_in  = {valid_ff[FRONT_LAT-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         valid_ff  <= '0;
      end else begin
         credit_ff <= credit_in;
         valid_ff  <= valid_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         geom_in.da[i] = DIFF_W'($signed(seg_a_end[i])) - DIFF_W'($signed(seg_a_start[i]));
         geom_in.db[i] = DIFF_W'($signed(seg_b_end[i])) - DIFF_W'($signed(seg_b_start[i]));
         geom_in.gp[i] = DIFF_W'($signed(seg_a_start[i])) - DIFF_W'($signed(seg_b_start[i]));
         geom_in.qs[i] = seg_b_start[i];
      end
   end

   always_ff @(posedge clock) begin
      geom_ff[0] <= geom_in;
      for (int k = 1; k < FRONT_LAT; k++) begin
         geom_ff[k] <= geom_ff[k-1];
      end
   end

   always_comb begin
      logic signed [DIFF_W-1:0] da, db, gp;
      logic signed [PROD_W-1:0] q_uu, q_uv, q_vv, q_uw, q_vw;
      for (int i = 0; i < 3; i++) begin
         da = $signed(geom_ff[0].da[i]);
         db = $signed(geom_ff[0].db[i]);
         gp = $signed(geom_ff[0].gp[i]);
         q_uu = da * da;
         q_uv = da * db;
         q_vv = db * db;
         q_uw = da * gp;
         q_vw = db * gp;
         prods_in.uu[i] = q_uu;
         prods_in.uv[i] = q_uv;
         prods_in.vv[i] = q_vv;
         prods_in.uw[i] = q_uw;
         prods_in.vw[i] = q_vw;
      end
   end

   always_ff @(posedge clock) begin
      prods_ff <= prods_in;
   end

   always_comb begin
      dots_in.uu = DOT_W'($signed(prods_ff.uu[0])) + DOT_W'($signed(prods_ff.uu[1]))
                 + DOT_W'($signed(prods_ff.uu[2]));
      dots_in.uv = DOT_W'($signed(prods_ff.uv[0])) + DOT_W'($signed(prods_ff.uv[1]))
                 + DOT_W'($signed(prods_ff.uv[2]));
      dots_in.vv = DOT_W'($signed(prods_ff.vv[0])) + DOT_W'($signed(prods_ff.vv[1]))
                 + DOT_W'($signed(prods_ff.vv[2]));
      dots_in.uw = DOT_W'($signed(prods_ff.uw[0])) + DOT_W'($signed(prods_ff.uw[1]))
                 + DOT_W'($signed(prods_ff.uw[2]));
      dots_in.vw = DOT_W'($signed(prods_ff.vw[0])) + DOT_W'($signed(prods_ff.vw[1]))
                 + DOT_W'($signed(prods_ff.vw[2]));
   end

   always_ff @(posedge clock) begin
      dots_ff[0] <= dots_in;
      for (int k = 1; k < DOT_STAGES; k++) begin
         dots_ff[k] <= dots_ff[k-1];
      end
   end

   ssd_wmul u_mul_uu_vv (.clock(clock), .op_a($signed(dots_ff[0].uu)),
                         .op_b($signed(dots_ff[0].vv)), .product(p_uu_vv));
   ssd_wmul u_mul_uv_uv (.clock(clock), .op_a($signed(dots_ff[0].uv)),
                         .op_b($signed(dots_ff[0].uv)), .product(p_uv_uv));
   ssd_wmul u_mul_uv_vw (.clock(clock), .op_a($signed(dots_ff[0].uv)),
                         .op_b($signed(dots_ff[0].vw)), .product(p_uv_vw));
   ssd_wmul u_mul_vv_uw (.clock(clock), .op_a($signed(dots_ff[0].vv)),
                         .op_b($signed(dots_ff[0].uw)), .product(p_vv_uw));
   ssd_wmul u_mul_uu_vw (.clock(clock), .op_a($signed(dots_ff[0].uu)),
                         .op_b($signed(dots_ff[0].vw)), .product(p_uu_vw));
   ssd_wmul u_mul_uv_uw (.clock(clock), .op_a($signed(dots_ff[0].uv)),
                         .op_b($signed(dots_ff[0].uw)), .product(p_uv_uw));

   always_comb begin
      det_in = p_uu_vv - p_uv_uv;
      ns0_in = p_uv_vw - p_vv_uw;
      nt0_in = p_uu_vw - p_uv_uw;
   end

   always_ff @(posedge clock) begin
      det_ff <= det_in;
      ns0_ff <= ns0_in;
      nt0_ff <= nt0_in;
   end

   // first pass: parallel test, then clamp s to the ends of segment a
   always_comb begin
      logic signed [WIDE_W-1:0] lim_w, vw_w, uv_w, vv_w;
      lim_w = $signed({{(WIDE_W-LIMIT_W){1'b0}}, limit});
      vw_w  = WIDE_W'($signed(dots_ff[3].vw));
      uv_w  = WIDE_W'($signed(dots_ff[3].uv));
      vv_w  = WIDE_W'($signed(dots_ff[3].vv));
      if (det_ff < lim_w) begin
         first_in.num_s = '0;
         first_in.den_s = WIDE_W'(1);
         first_in.num_t = vw_w;
         first_in.den_t = vv_w;
      end else if (ns0_ff < 0) begin
         first_in.num_s = '0;
         first_in.den_s = det_ff;
         first_in.num_t = vw_w;
         first_in.den_t = vv_w;
      end else if (ns0_ff > det_ff) begin
         first_in.num_s = det_ff;
         first_in.den_s = det_ff;
         first_in.num_t = vw_w + uv_w;
         first_in.den_t = vv_w;
      end else begin
         first_in.num_s = ns0_ff;
         first_in.den_s = det_ff;
         first_in.num_t = nt0_ff;
         first_in.den_t = det_ff;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
   end

   // second pass: clamp t to the ends of segment b and redo s at that edge
   always_comb begin
      logic signed [WIDE_W-1:0] uu_w, uw_w, uv_w, h, nt, dt;
      logic                     edge_hit;
      uu_w     = WIDE_W'($signed(dots_ff[4].uu));
      uw_w     = WIDE_W'($signed(dots_ff[4].uw));
      uv_w     = WIDE_W'($signed(dots_ff[4].uv));
      nt       = $signed(first_ff.num_t);
      dt       = $signed(first_ff.den_t);
      second_in = first_ff;
      edge_hit = 1'b0;
      h        = '0;
      if (nt < 0) begin
         second_in.num_t = '0;
         h        = -uw_w;
         edge_hit = 1'b1;
      end else if (nt > dt) begin
         second_in.num_t = dt;
         h        = uv_w - uw_w;
         edge_hit = 1'b1;
      end
      if (edge_hit) begin
         if (h < 0) begin
            second_in.num_s = '0;
         end else if (h > uu_w) begin
            second_in.num_s = first_ff.den_s;
         end else begin
            second_in.num_s = h;
            second_in.den_s = uu_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      second_ff <= second_in;
   end

   assign push       = valid_ff[FRONT_LAT-1];
   assign job.geom   = geom_ff[FRONT_LAT-1];
   assign job.ratio  = second_ff;

endmodule

### rtl/ssd_queue.sv
// job queue between front and back end, memory with registered read
module ssd_queue import ssd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type wr_data,
   output logic    pop,
   output logic    rd_valid,
   output job_type rd_data
);

   job_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CREDIT_W-1:0]   count_in, count_ff;
   logic                  rd_valid_ff;
   job_type               rd_data_ff;

   // the back end never stalls, so anything queued leaves at once
   assign pop      = (count_ff != '0);
   assign count_in = count_ff + CREDIT_W'(push) - CREDIT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         count_ff    <= count_in;
         rd_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
      if (pop) begin
         rd_data_ff <= mem_ff[rd_ptr_ff];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_data  = rd_data_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CREDIT_W'(QUEUE_DEPTH)))
      else $error("queue written while full");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |=> rd_valid_ff)
      else $error("queued job not read out");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |=> !rd_valid_ff)
      else $error("read beat from an empty queue");
`endif

endmodule

### rtl/ssd_div.sv
// pipelined fraction divider, one quotient bit per stage, with the edge cases up front
module ssd_div import ssd_pkg::*; (
   input  logic                     clock,
   input  logic signed [WIDE_W-1:0] num,
   input  logic signed [WIDE_W-1:0] den,
   input  logic [LIMIT_W-1:0]       limit,
   output logic [FRAC_W-1:0]        frac
);

   logic [WIDE_W-1:0]    rem_ff  [FRAC_BITS+1];
   logic [WIDE_W-1:0]    den_ff  [FRAC_BITS+1];
   logic [FRAC_BITS-1:0] quo_ff  [FRAC_BITS+1];
   logic                 zero_ff [FRAC_BITS+1];
   logic                 one_ff  [FRAC_BITS+1];
   logic                 zero_in, one_in;
   logic [FRAC_W-1:0]    frac_in, frac_ff;

   always_comb begin
      logic signed [WIDE_W-1:0] lim_w;
      lim_w   = $signed({{(WIDE_W-LIMIT_W){1'b0}}, limit});
      // negative or near-zero numerator, or a non-positive denominator, give zero
      zero_in = (num < lim_w) || (num < 0) || (den <= 0);
      one_in  = !zero_in && (num >= den);
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= num;
      den_ff[0]  <= den;
      quo_ff[0]  <= '0;
      zero_ff[0] <= zero_in;
      one_ff[0]  <= one_in;
   end

   for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
      logic [WIDE_W-1:0]    rem_sh;
      logic [WIDE_W-1:0]    rem_in;
      logic [FRAC_BITS-1:0] quo_in;

      always_comb begin
         rem_sh = {rem_ff[k-1][WIDE_W-2:0], 1'b0};
         if (rem_sh >= den_ff[k-1]) begin
            rem_in = rem_sh - den_ff[k-1];
            quo_in = {quo_ff[k-1][FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[k-1][FRAC_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         den_ff[k]  <= den_ff[k-1];
         quo_ff[k]  <= quo_in;
         zero_ff[k] <= zero_ff[k-1];
         one_ff[k]  <= one_ff[k-1];
      end
   end

   always_comb begin
      priority if (zero_ff[FRAC_BITS]) begin
         frac_in = '0;
      end else if (one_ff[FRAC_BITS]) begin
         frac_in = FRAC_ONE;
      end else begin
         frac_in = {1'b0, quo_ff[FRAC_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      frac_ff <= frac_in;
   end

   assign frac = frac_ff;

endmodule

### rtl/ssd_sqrt.sv
// pipelined integer square root, one root bit per stage, rounded down
module ssd_sqrt import ssd_pkg::*; (
   input  logic                clock,
   input  logic [SQ_W-1:0]     radicand,
   output logic [ROOT_W-1:0]   root
);

   localparam int REM_W = ROOT_W + 2;

   logic [SQ_W-1:0]   rad_ff  [SQRT_LAT];
   logic [REM_W-1:0]  rem_ff  [SQRT_LAT];
   logic [ROOT_W-1:0] root_ff [SQRT_LAT];

   for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
      logic [SQ_W-1:0]   rad_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [REM_W-1:0]  rem_sh, trial, rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign rad_prev  = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_prev[REM_W-3:0], rad_prev[SQ_W-1:SQ_W-2]};
         trial  = {root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[k]  <= {rad_prev[SQ_W-3:0], 2'b00};
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
      end
   end

   assign root = root_ff[SQRT_LAT-1];

endmodule

### rtl/ssd_back.sv
// back end: fractions, closest point on segment b, squared gap and its root
module ssd_back import ssd_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [LIMIT_W-1:0]          limit,
   input  logic                        in_valid,
   input  job_type                     in_job,
   output logic                        out_valid,
   output logic [DIST_W-1:0]           distance,
   output logic [2:0][COORD_W-1:0]     point
);

   logic [BACK_LAT-1:0]               valid_ff;
   geom_type                          geom_ff [DIV_LAT];
   logic [FRAC_W-1:0]                 frac_s, frac_t;
   logic [2:0][ALONG_W-1:0]           pa_in, pa_ff, pb_in, pb_ff;
   logic [2:0][DIFF_W-1:0]            gp_ff;
   logic [2:0][COORD_W-1:0]           qs_ff;
   logic [2:0][DELTA_W-1:0]           delta_in, delta_ff;
   logic [2:0][COORD_W-1:0]           point_in;
   logic [2:0][COORD_W-1:0]           point_ff [PT_LAT];
   logic [2:0][SQ_W-1:0]              sqr_in, sqr_ff;
   logic [SQ_W-1:0]                   sq_in, sq_ff;
   logic [ROOT_W-1:0]                 root;
   logic [DIST_W-1:0]                 dist_in, dist_ff;
   logic [2:0][COORD_W-1:0]           point_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[BACK_LAT-2:0], in_valid};
      end
   end

   ssd_div u_div_s (.clock(clock), .num($signed(in_job.ratio.num_s)),
                    .den($signed(in_job.ratio.den_s)), .limit(limit), .frac(frac_s));
   ssd_div u_div_t (.clock(clock), .num($signed(in_job.ratio.num_t)),
                    .den($signed(in_job.ratio.den_t)), .limit(limit), .frac(frac_t));

   always_ff @(posedge clock) begin
      geom_ff[0] <= in_job.geom;
      for (int k = 1; k < DIV_LAT; k++) begin
         geom_ff[k] <= geom_ff[k-1];
      end
   end

   always_comb begin
      logic signed [ALONG_W-1:0] a, b;
      for (int i = 0; i < 3; i++) begin
         a = $signed({1'b0, frac_s}) * $signed(geom_ff[DIV_LAT-1].da[i]);
         b = $signed({1'b0, frac_t}) * $signed(geom_ff[DIV_LAT-1].db[i]);
         pa_in[i] = a;
         pb_in[i] = b;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      gp_ff <= geom_ff[DIV_LAT-1].gp;
      qs_ff <= geom_ff[DIV_LAT-1].qs;
   end

   // back to units of 2^-16, nearest with ties up
   always_comb begin
      logic signed [SUM_W-1:0] gap, gap_r, gap_q, along, along_r, along_q;
      for (int i = 0; i < 3; i++) begin
         gap     = (SUM_W'($signed(gp_ff[i])) <<< FRAC_BITS)
                 + SUM_W'($signed(pa_ff[i])) - SUM_W'($signed(pb_ff[i]));
         gap_r   = gap + $signed(SUM_W'(ROUND_HALF));
         gap_q   = gap_r >>> FRAC_BITS;
         along   = SUM_W'($signed(pb_ff[i]));
         along_r = along + $signed(SUM_W'(ROUND_HALF));
         along_q = along_r >>> FRAC_BITS;
         delta_in[i] = gap_q[DELTA_W-1:0];
         point_in[i] = qs_ff[i] + along_q[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      delta_ff    <= delta_in;
      point_ff[0] <= point_in;
      for (int k = 1; k < PT_LAT; k++) begin
         point_ff[k] <= point_ff[k-1];
      end
   end

   always_comb begin
      logic signed [DELTA_W-1:0] d;
      logic signed [SQ_W-1:0]    d2;
      for (int i = 0; i < 3; i++) begin
         d         = $signed(delta_ff[i]);
         d2        = d * d;
         sqr_in[i] = d2;
      end
   end

   always_ff @(posedge clock) begin
      sqr_ff <= sqr_in;
   end

   assign sq_in = sqr_ff[0] + sqr_ff[1] + sqr_ff[2];

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   ssd_sqrt u_sqrt (.clock(clock), .radicand(sq_ff), .root(root));

   assign dist_in = (|root[ROOT_W-1:DIST_W]) ? '1 : root[DIST_W-1:0];

   always_ff @(posedge clock) begin
      dist_ff      <= dist_in;
      point_out_ff <= point_ff[PT_LAT-1];
   end

   assign out_valid = valid_ff[BACK_LAT-1];
   assign distance  = dist_ff;
   assign point     = point_out_ff;

endmodule

### rtl/segment_segment_distance_3d_top.sv
// Shortest distance between two 3D segments and the closest point on the second one.
//
// Input: pulse start with both segments' endpoints (signed Q8.16) on the req_ ports;
// a beat is taken at a clock edge where start is high and busy is low. busy only
// rises when the internal job queue has run out of credits.
// Output: rsp_valid is high for one cycle with rsp_shortest_distance (unsigned
// Q9.16, rounded down) and rsp_near_point_x/y/z (Q8.16, rounded to nearest).
// The receiver cannot hold results off; the block never needs it to.
// The pipeline holds two-stage wide multipliers, 18-stage fraction dividers and
// the 27-stage square root. A beat can be taken every cycle while busy is low.
// csr_valid/csr_data write the near-zero limit; csr_ready is always high, and the
// limit must only change while no beat is in flight.
// Synchronous reset empties the pipeline and queue and sets the limit to 1.
module segment_segment_distance_3d_top import ssd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_seg_a_start_x,
   input  logic signed [COORD_W-1:0] req_seg_a_start_y,
   input  logic signed [COORD_W-1:0] req_seg_a_start_z,
   input  logic signed [COORD_W-1:0] req_seg_a_end_x,
   input  logic signed [COORD_W-1:0] req_seg_a_end_y,
   input  logic signed [COORD_W-1:0] req_seg_a_end_z,
   input  logic signed [COORD_W-1:0] req_seg_b_start_x,
   input  logic signed [COORD_W-1:0] req_seg_b_start_y,
   input  logic signed [COORD_W-1:0] req_seg_b_start_z,
   input  logic signed [COORD_W-1:0] req_seg_b_end_x,
   input  logic signed [COORD_W-1:0] req_seg_b_end_y,
   input  logic signed [COORD_W-1:0] req_seg_b_end_z,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [LIMIT_W-1:0]        csr_data,
   output logic                      rsp_valid,
   output logic [DIST_W-1:0]         rsp_shortest_distance,
   output logic signed [COORD_W-1:0] rsp_near_point_x,
   output logic signed [COORD_W-1:0] rsp_near_point_y,
   output logic signed [COORD_W-1:0] rsp_near_point_z
);

   logic [LIMIT_W-1:0]        limit_ff;
   logic [2:0][COORD_W-1:0]   seg_a_start, seg_a_end, seg_b_start, seg_b_end;
   logic                      push, pop, rd_valid;
   job_type                   wr_job, rd_job;
   logic [2:0][COORD_W-1:0]   point;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   assign seg_a_start = {req_seg_a_start_z, req_seg_a_start_y, req_seg_a_start_x};
   assign seg_a_end   = {req_seg_a_end_z, req_seg_a_end_y, req_seg_a_end_x};
   assign seg_b_start = {req_seg_b_start_z, req_seg_b_start_y, req_seg_b_start_x};
   assign seg_b_end   = {req_seg_b_end_z, req_seg_b_end_y, req_seg_b_end_x};

   ssd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .seg_a_start (seg_a_start),
      .seg_a_end   (seg_a_end),
      .seg_b_start (seg_b_start),
      .seg_b_end   (seg_b_end),
      .limit       (limit_ff),
      .pop         (pop),
      .push        (push),
      .job         (wr_job)
   );

   ssd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_data  (wr_job),
      .pop      (pop),
      .rd_valid (rd_valid),
      .rd_data  (rd_job)
   );

   ssd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit_ff),
      .in_valid  (rd_valid),
      .in_job    (rd_job),
      .out_valid (rsp_valid),
      .distance  (rsp_shortest_distance),
      .point     (point)
   );

   assign rsp_near_point_x = point[0];
   assign rsp_near_point_y = point[1];
   assign rsp_near_point_z = point[2];

endmodule

### bench/ssd_checker.sv
// checker for the segment distance block: predicts each result and compares it
`timescale 1ns / 1ps
module ssd_checker import ssd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic signed [COORD_W-1:0] req_seg_a_start_x,
   input  logic signed [COORD_W-1:0] req_seg_a_start_y,
   input  logic signed [COORD_W-1:0] req_seg_a_start_z,
   input  logic signed [COORD_W-1:0] req_seg_a_end_x,
   input  logic signed [COORD_W-1:0] req_seg_a_end_y,
   input  logic signed [COORD_W-1:0] req_seg_a_end_z,
   input  logic signed [COORD_W-1:0] req_seg_b_start_x,
   input  logic signed [COORD_W-1:0] req_seg_b_start_y,
   input  logic signed [COORD_W-1:0] req_seg_b_start_z,
   input  logic signed [COORD_W-1:0] req_seg_b_end_x,
   input  logic signed [COORD_W-1:0] req_seg_b_end_y,
   input  logic signed [COORD_W-1:0] req_seg_b_end_z,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [LIMIT_W-1:0]        csr_data,
   input  logic                      rsp_valid,
   input  logic [DIST_W-1:0]         rsp_shortest_distance,
   input  logic signed [COORD_W-1:0] rsp_near_point_x,
   input  logic signed [COORD_W-1:0] rsp_near_point_y,
   input  logic signed [COORD_W-1:0] rsp_near_point_z,
   output int                        fail_count,
   output int                        pending
);

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [DIST_W-1:0]         distance;
      logic signed [COORD_W-1:0] pt [3];
   } gap_type;

   gap_type     gap_queue [$];
   logic [LIMIT_W-1:0] zero_limit;

   assign pending = gap_queue.size();

   function automatic longint frac_of(wide_type num, wide_type den, logic [LIMIT_W-1:0] lim);
      wide_type wl;
      wl = {96'b0, lim};
      if (num < 0 || num < wl) return 0;
      if (den <= 0) return 0;
      if (num >= den) return 65536;
      return longint'((num <<< 16) / den);
   endfunction

   // floor of (x + half) / 2^16
   function automatic longint round16(longint x);
      return (x + 32768) >>> 16;
   endfunction

   function automatic longint unsigned root64(longint unsigned x);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (x >= res + bit_v) begin
            x = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic gap_type segment_gap(longint c [12], logic [LIMIT_W-1:0] lim);
      longint da [3], db [3], gp [3];
      longint uu, uv, vv, uw, vw, h, fs, ft, along, diff;
      longint unsigned sq, root;
      wide_type det, ns, ds, nt, dt, wuu, wuv, wvv, wuw, wvw;
      gap_type g;
      uu = 0; uv = 0; vv = 0; uw = 0; vw = 0; sq = 0;
      for (int i = 0; i < 3; i++) begin
         da[i] = c[3+i] - c[i];
         db[i] = c[9+i] - c[6+i];
         gp[i] = c[i] - c[6+i];
      end
      for (int i = 0; i < 3; i++) begin
         uu += da[i] * da[i];
         uv += da[i] * db[i];
         vv += db[i] * db[i];
         uw += da[i] * gp[i];
         vw += db[i] * gp[i];
      end
      wuu = uu; wuv = uv; wvv = vv; wuw = uw; wvw = vw;
      det = wuu * wvv - wuv * wuv;
      if (det < 0 || det < {96'b0, lim}) begin
         ns = 0; ds = 1; nt = wvw; dt = wvv;
      end else begin
         ns = wuv * wvw - wvv * wuw;
         nt = wuu * wvw - wuv * wuw;
         ds = det; dt = det;
         if (ns < 0) begin
            ns = 0; nt = wvw; dt = wvv;
         end else if (ns > ds) begin
            ns = ds; nt = wvw + wuv; dt = wvv;
         end
      end
      // edge recompute of s once t is clamped
      if (nt < 0 || nt > dt) begin
         if (nt < 0) begin
            nt = 0;
            h = -uw;
         end else begin
            nt = dt;
            h = uv - uw;
         end
         if (h < 0) ns = 0;
         else if (h > uu) ns = ds;
         else begin
            ns = h; ds = wuu;
         end
      end
      fs = frac_of(ns, ds, lim);
      ft = frac_of(nt, dt, lim);
      for (int i = 0; i < 3; i++) begin
         along = ft * db[i];
         diff = round16(gp[i] * 65536 + fs * da[i] - along);
         sq += longint'(diff * diff);
         g.pt[i] = COORD_W'(c[6+i] + round16(along));
      end
      root = root64(sq);
      g.distance = (root > 64'h1FFFFFF) ? 25'h1FFFFFF : DIST_W'(root);
      return g;
   endfunction

   always @(posedge clock) begin
      longint c [12];
      gap_type exp_g;
      if (reset) begin
         zero_limit <= LIMIT_RESET;
         gap_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) zero_limit <= csr_data;
         if (start && !busy) begin
            c = '{req_seg_a_start_x, req_seg_a_start_y, req_seg_a_start_z,
                  req_seg_a_end_x, req_seg_a_end_y, req_seg_a_end_z,
                  req_seg_b_start_x, req_seg_b_start_y, req_seg_b_start_z,
                  req_seg_b_end_x, req_seg_b_end_y, req_seg_b_end_z};
            gap_queue.push_back(segment_gap(c, zero_limit));
         end
         if (rsp_valid) begin
            if (gap_queue.size() == 0) begin
               $display("%0t: result with none expected, dist %h", $time,
                        rsp_shortest_distance);
               fail_count <= fail_count + 1;
            end else begin
               exp_g = gap_queue.pop_front();
               if (exp_g.distance !== rsp_shortest_distance ||
                   exp_g.pt[0] !== rsp_near_point_x ||
                   exp_g.pt[1] !== rsp_near_point_y ||
                   exp_g.pt[2] !== rsp_near_point_z) begin
                  $display("%0t: mismatch exp dist %h pt %h %h %h got dist %h pt %h %h %h",
                           $time, exp_g.distance, exp_g.pt[0], exp_g.pt[1], exp_g.pt[2],
                           rsp_shortest_distance, rsp_near_point_x,
                           rsp_near_point_y, rsp_near_point_z);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### bench/tb.sv
// testbench top: stimulus, limit settings and verdict for the segment distance block
`timescale 1ns / 1ps
module tb;
   import ssd_pkg::*;

   localparam int U        = 65536;
   localparam int DRAIN    = 70;
   localparam int WATCHDOG = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy, csr_ready, rsp_valid;
   logic csr_valid = 1'b0;
   logic [LIMIT_W-1:0] csr_data = '0;
   logic signed [COORD_W-1:0] coord [12];
   logic [DIST_W-1:0] rsp_shortest_distance;
   logic signed [COORD_W-1:0] rsp_near_point_x, rsp_near_point_y, rsp_near_point_z;
   int fail_count, pending, idle_pct, quiet;

   initial for (int i = 0; i < 12; i++) coord[i] = '0;

   always #10 clock = ~clock;

   segment_segment_distance_3d_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_seg_a_start_x(coord[0]), .req_seg_a_start_y(coord[1]),
      .req_seg_a_start_z(coord[2]), .req_seg_a_end_x(coord[3]),
      .req_seg_a_end_y(coord[4]), .req_seg_a_end_z(coord[5]),
      .req_seg_b_start_x(coord[6]), .req_seg_b_start_y(coord[7]),
      .req_seg_b_start_z(coord[8]), .req_seg_b_end_x(coord[9]),
      .req_seg_b_end_y(coord[10]), .req_seg_b_end_z(coord[11]),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_shortest_distance(rsp_shortest_distance),
      .rsp_near_point_x(rsp_near_point_x), .rsp_near_point_y(rsp_near_point_y),
      .rsp_near_point_z(rsp_near_point_z)
   );

   ssd_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_seg_a_start_x(coord[0]), .req_seg_a_start_y(coord[1]),
      .req_seg_a_start_z(coord[2]), .req_seg_a_end_x(coord[3]),
      .req_seg_a_end_y(coord[4]), .req_seg_a_end_z(coord[5]),
      .req_seg_b_start_x(coord[6]), .req_seg_b_start_y(coord[7]),
      .req_seg_b_start_z(coord[8]), .req_seg_b_end_x(coord[9]),
      .req_seg_b_end_y(coord[10]), .req_seg_b_end_z(coord[11]),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_shortest_distance(rsp_shortest_distance),
      .rsp_near_point_x(rsp_near_point_x), .rsp_near_point_y(rsp_near_point_y),
      .rsp_near_point_z(rsp_near_point_z),
      .fail_count(fail_count), .pending(pending)
   );

   // stall detector: cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= WATCHDOG) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   task automatic send_pair(input int c [12]);
      logic taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      for (int i = 0; i < 12; i++) coord[i] <= COORD_W'(c[i]);
      start <= 1'b1;
      // busy only moves at rising edges, so its value here holds at the next one
      do begin
         taken = !busy;
         @(negedge clock);
      end while (!taken);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      logic taken;
      start <= 1'b0;
      csr_data <= value;
      csr_valid <= 1'b1;
      do begin
         @(negedge clock);
         taken = csr_ready;
      end while (!taken);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   function automatic int rnd_range(int span);
      return $urandom_range(2 * span) - span;
   endfunction

   function automatic void random_pair(output int c [12]);
      int mode, k;
      mode = $urandom_range(5);
      for (int i = 0; i < 12; i++) c[i] = rnd_range(4 * U);
      case (mode)
         0: for (int i = 0; i < 12; i++) c[i] = int'($urandom) <<< 8 >>> 8;
         1: ;
         2: begin
            // parallel or antiparallel, with an offset
            k = rnd_range(2);
            if (k == 0) k = 1;
            for (int i = 0; i < 3; i++) c[9+i] = c[6+i] + k * (c[3+i] - c[i]);
         end
         3: begin
            if ($urandom_range(1)) for (int i = 0; i < 3; i++) c[3+i] = c[i];
            else for (int i = 0; i < 3; i++) c[9+i] = c[6+i];
         end
         4: for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
         default: for (int i = 0; i < 12; i++) c[i] = rnd_range(8);
      endcase
   endfunction

   initial begin
      int c [12];
      logic [LIMIT_W-1:0] limits [5];
      int pcts [5];
      int hi, lo;
      hi = 24'sh7FFFFF;
      lo = -8388608;
      limits = '{32'd0, 32'hFFFFFFFF, 32'd1, 32'd0, 32'd4096};
      pcts = '{0, 73, 15, 73, 0};
      idle_pct = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, degenerate segments, parallel lines, clamped ends
      c = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};                         send_pair(c);
      c = '{lo, lo, lo, hi, hi, hi, hi, hi, hi, lo, lo, lo};             send_pair(c);
      c = '{lo, lo, lo, hi, hi, hi, lo, hi, lo, hi, lo, hi};             send_pair(c);
      c = '{hi, lo, hi, lo, hi, lo, hi, hi, hi, lo, lo, lo};             send_pair(c);
      c = '{0, 0, 0, U, 0, 0, 0, 0, U, U, 0, U};                         send_pair(c);
      c = '{-U, 0, 0, U, 0, 0, 0, -U, U, 0, U, U};                       send_pair(c);
      c = '{0, 0, 0, U, 0, 0, 5*U, -U, 0, 5*U, U, 0};                    send_pair(c);
      c = '{0, 0, 0, U, 0, 0, -5*U, -U, 0, -5*U, U, 0};                  send_pair(c);
      c = '{0, 0, 0, U, 0, 0, 0, 3*U, U, 0, 5*U, U};                     send_pair(c);
      c = '{0, 0, 0, U, 0, 0, 0, -5*U, U, 0, -3*U, U};                   send_pair(c);
      c = '{U, U, U, U, U, U, 0, 0, 0, 2*U, 0, 0};                       send_pair(c);
      c = '{U, U, U, U, U, U, -U, 0, 0, -U, 0, 0};                       send_pair(c);
      c = '{0, 0, 0, 4*U, 0, 0, U, U, 0, 3*U, U, 0};                     send_pair(c);
      c = '{0, 0, 0, 4*U, 0, 0, 6*U, U, 0, 2*U, U, 0};                   send_pair(c);
      c = '{0, 0, 0, 4*U, 0, 0, 6*U, U, 0, 9*U, U, 0};                   send_pair(c);
      c = '{0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 1, 1};                         send_pair(c);
      c = '{0, 0, 0, 1, 1, 0, 0, 0, 0, 1, 1, 1};                         send_pair(c);
      c = '{hi, hi, hi, hi, hi, hi, lo, lo, lo, lo, lo, lo};             send_pair(c);
      c = '{lo, 0, hi, hi, 0, lo, 0, lo, 0, 0, hi, 0};                   send_pair(c);
      c = '{hi, 0, 0, lo, 0, 0, hi, 1, 0, lo, 1, 0};                     send_pair(c);
      drain();

      for (int p = 0; p < 5; p++) begin
         write_limit(p == 3 ? LIMIT_W'($urandom) : limits[p]);
         idle_pct = pcts[p];
         for (int n = 0; n < 180; n++) begin
            // short bursts with no gaps inside the idling phases
            if (pcts[p] != 0) idle_pct = ($urandom_range(9) < 2) ? 0 : pcts[p];
            random_pair(c);
            send_pair(c);
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### segment_segment_distance_3d_top.f
rtl/ssd_pkg.sv
rtl/ssd_wmul.sv
rtl/ssd_front.sv
rtl/ssd_queue.sv
rtl/ssd_div.sv
rtl/ssd_sqrt.sv
rtl/ssd_back.sv
rtl/segment_segment_distance_3d_top.sv
bench/ssd_checker.sv
bench/tb.sv
